@@ rtl/core/mpsd_pkg.sv @@
// Shared constants and types of the multi-pattern substring detector.
`timescale 1ns / 1ps

package mpsd_pkg;

    localparam int NUM_SLOTS_DEF       = 18;
    localparam int MAX_PATTERN_LEN_DEF = 256;
    localparam int CHAR_BITS           = 16;

    // A pattern opening with this code unit and holding it again after the prefix carries a format prefix.
    localparam logic [CHAR_BITS-1:0] PERCENT_CHAR = CHAR_BITS'(16'h0025);
    localparam int FMT_SKIP = 4;

    // Transaction kinds carried on tuser.
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_PATTERN = 2'd1;
    localparam logic [1:0] ACT_TEXT    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIX_RD,
        ST_FIX_SCAN,
        ST_TXT_RUN,
        ST_RESULT
    } state_t;

    // Control of the partial-match memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_row;
        logic clr_all;
    } pmv_cmd_t;

endpackage

@@ rtl/core/mpsd_pat_mem.sv @@
// Pattern store: one wide row per slot, written one code unit at a time.
`timescale 1ns / 1ps

module mpsd_pat_mem #(
    parameter int NUM_SLOTS       = mpsd_pkg::NUM_SLOTS_DEF,
    parameter int MAX_PATTERN_LEN = mpsd_pkg::MAX_PATTERN_LEN_DEF,
    parameter int SLOT_W          = 5,
    parameter int LANE_W          = 8
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [SLOT_W-1:0]                             wr_row,
    input  logic [LANE_W-1:0]                             wr_lane,
    input  logic [mpsd_pkg::CHAR_BITS-1:0]                wr_data,
    input  logic                                          rd_en,
    input  logic [SLOT_W-1:0]                             rd_row,
    output logic [MAX_PATTERN_LEN*mpsd_pkg::CHAR_BITS-1:0] rd_data
);
    import mpsd_pkg::*;

    localparam int ROW_BITS = MAX_PATTERN_LEN * CHAR_BITS;

    logic [ROW_BITS-1:0] mem [NUM_SLOTS];
    logic [ROW_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row][wr_lane*CHAR_BITS +: CHAR_BITS] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/mpsd_pmv_mem.sv @@
// Partial-match vectors: one row per slot, with a valid bit per row so that
// cleared rows read as all zeros.
`timescale 1ns / 1ps

module mpsd_pmv_mem #(
    parameter int NUM_SLOTS       = mpsd_pkg::NUM_SLOTS_DEF,
    parameter int MAX_PATTERN_LEN = mpsd_pkg::MAX_PATTERN_LEN_DEF,
    parameter int SLOT_W          = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mpsd_pkg::pmv_cmd_t         cmd,
    input  logic [SLOT_W-1:0]          rd_row,
    input  logic [SLOT_W-1:0]          wr_row,
    input  logic [SLOT_W-1:0]          clr_row,
    input  logic [MAX_PATTERN_LEN-1:0] wr_data,
    output logic [MAX_PATTERN_LEN-1:0] rd_data
);
    import mpsd_pkg::*;

    logic [MAX_PATTERN_LEN-1:0] mem [NUM_SLOTS];
    logic [MAX_PATTERN_LEN-1:0] rd_data_reg;
    logic [NUM_SLOTS-1:0]       row_valid_reg;
    logic                       rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_row];
            end
            if (cmd.clr_all)
            begin
                row_valid_reg <= '0;
            end
            else
            begin
                if (cmd.wr_en)
                begin
                    row_valid_reg[wr_row] <= 1'b1;
                end
                if (cmd.clr_row)
                begin
                    row_valid_reg[clr_row] <= 1'b0;
                end
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/core/mpsd_lane_update.sv @@
// Shift-and update of one slot's partial-match vector for one text unit.
`timescale 1ns / 1ps

module mpsd_lane_update #(
    parameter int MAX_PATTERN_LEN = mpsd_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic [MAX_PATTERN_LEN*mpsd_pkg::CHAR_BITS-1:0] pat_row,
    input  logic                                           start4,
    input  logic [MAX_PATTERN_LEN-1:0]                     vec_in,
    input  logic [mpsd_pkg::CHAR_BITS-1:0]                 text_char,
    output logic [MAX_PATTERN_LEN-1:0]                     vec_out
);
    import mpsd_pkg::*;

    for (genvar k = 0; k < MAX_PATTERN_LEN; k++)
    begin : g_lane
        logic [CHAR_BITS-1:0] seg_char;
        logic                 prev;

        if (k + FMT_SKIP < MAX_PATTERN_LEN)
        begin : g_shift
            assign seg_char = start4 ? pat_row[(k+FMT_SKIP)*CHAR_BITS +: CHAR_BITS]
                                     : pat_row[k*CHAR_BITS +: CHAR_BITS];
        end
        else
        begin : g_edge
            assign seg_char = start4 ? '0 : pat_row[k*CHAR_BITS +: CHAR_BITS];
        end

        if (k == 0)
        begin : g_first
            assign prev = 1'b1;
        end
        else
        begin : g_rest
            assign prev = vec_in[k-1];
        end

        assign vec_out[k] = prev && (seg_char == text_char);
    end

endmodule

@@ rtl/core/multi_pattern_substring_detector.sv @@
// Top level of the multi-pattern substring detector.
`timescale 1ns / 1ps

// Pattern strings are written code unit by code unit into slots (tuser =
// pattern) and can be dropped (tuser = clear); text then streams in (tuser =
// text) and the transaction marked tlast produces one result transaction whose
// bit 0 says whether any loaded slot's search segment occurred in the text. A
// clear, or a pattern unit without tlast, leaves the input ready for the next
// unit; with tlast the slot is fixed by reading its row and scanning it one code
// unit a cycle, with the input stalled. Each text unit walks the slots through
// the two row memories (pattern row and match row, read, updated and written
// back one slot per cycle), and the input is stalled until the walk is done; a
// zero unit or a unit after it is taken without a walk.
// After the last text unit the result is loaded into an output register once
// that register is free or being taken, and the register holds it until taken
// while new input is accepted. Everything resets to empty slots; no clearing
// pass is needed.
module multi_pattern_substring_detector #(
    parameter int NUM_SLOTS       = mpsd_pkg::NUM_SLOTS_DEF,
    parameter int MAX_PATTERN_LEN = mpsd_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // slot[4:0], position[12:5], character[28:13], zeros
    input  logic        s_axis_tlast,  // last unit of a pattern or of the text
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // found[0], zeros
);
    import mpsd_pkg::*;

    localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LANE_W   = $clog2(MAX_PATTERN_LEN);
    localparam int LEN_W    = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CNT_W    = $clog2(NUM_SLOTS + 1);
    localparam int ROW_BITS = MAX_PATTERN_LEN * CHAR_BITS;

    // Input fields.
    logic                 in_accept;
    logic [1:0]           in_action;
    logic [4:0]           in_slot;
    logic [7:0]           in_pos;
    logic [CHAR_BITS-1:0] in_char;
    logic                 slot_ok;
    logic                 pos_ok;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_action = s_axis_tuser;
    assign in_slot   = s_axis_tdata[4:0];
    assign in_pos    = s_axis_tdata[12:5];
    assign in_char   = s_axis_tdata[28:13];
    assign slot_ok   = 7'(in_slot) < 7'(NUM_SLOTS);
    assign pos_ok    = 11'(in_pos) < 11'(MAX_PATTERN_LEN);

    // Control state.
    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    cur_slot_reg, cur_slot_next;
    logic [7:0]           cur_pos_reg, cur_pos_next;
    logic [CHAR_BITS-1:0] cur_char_reg, cur_char_next;
    logic                 cur_last_reg, cur_last_next;
    logic [LEN_W-1:0]     idx_reg, idx_next;
    logic                 pct_found_reg, pct_found_next;
    logic [LEN_W-1:0]     pct_idx_reg, pct_idx_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 hit_reg, hit_next;
    logic                 halted_reg, halted_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;

    // Per-slot descriptors, fixed when a pattern's last unit arrives.
    logic [LEN_W-1:0]     len_reg [NUM_SLOTS];
    logic [LEN_W-1:0]     seg_len_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] start4_reg;

    // Memory interfaces.
    logic                       pat_wr_en;
    logic                       pat_rd_en;
    logic [SLOT_W-1:0]          pat_rd_row;
    logic [ROW_BITS-1:0]        pat_row;
    pmv_cmd_t                   pmv_cmd;
    logic [SLOT_W-1:0]          pmv_clr_row;
    logic [MAX_PATTERN_LEN-1:0] pmv_rd_data;
    logic [MAX_PATTERN_LEN-1:0] pmv_new;

    // Slot fixing.
    logic [CHAR_BITS-1:0] scan_char;
    logic                 scan_stop;
    logic                 qualify;
    logic [LEN_W-1:0]     fix_seg_len;
    logic                 fix_done;

    // Text sweep.
    logic [SLOT_W-1:0]    proc_slot;
    logic                 proc_en;
    logic                 proc_active;
    logic                 proc_hit;
    logic                 issue_en;
    logic [LEN_W-1:0]     proc_seg_len;

    logic                 clr_en;
    logic                 result_load;

    assign s_axis_tready = (state_reg == ST_IDLE);

    assign pat_wr_en = in_accept && (in_action == ACT_PATTERN) && slot_ok && pos_ok;
    assign clr_en    = in_accept && (in_action == ACT_CLEAR) && slot_ok;

    // The scan walks the freshly read row until the first zero unit or past
    // the position of the last written unit.
    assign scan_char = pat_row[LANE_W'(idx_reg)*CHAR_BITS +: CHAR_BITS];
    assign scan_stop = (11'(idx_reg) > 11'(cur_pos_reg)) || (scan_char == '0);
    assign qualify   = (idx_reg > LEN_W'(FMT_SKIP))
                       && (pat_row[CHAR_BITS-1:0] == PERCENT_CHAR) && pct_found_reg;
    assign fix_seg_len = qualify ? (pct_idx_reg - LEN_W'(FMT_SKIP)) : idx_reg;
    assign fix_done    = (state_reg == ST_FIX_SCAN) && scan_stop;

    // Slot reads are issued in the cycle before that slot is updated.
    assign issue_en     = (state_reg == ST_TXT_RUN) && (cnt_reg < CNT_W'(NUM_SLOTS));
    assign proc_en      = (state_reg == ST_TXT_RUN) && (cnt_reg != '0);
    assign proc_slot    = SLOT_W'(cnt_reg - CNT_W'(1));
    assign proc_seg_len = seg_len_reg[proc_slot];
    assign proc_active  = (len_reg[proc_slot] != '0) && (proc_seg_len != '0);
    assign proc_hit     = proc_en && proc_active
                          && pmv_new[LANE_W'(proc_seg_len - LEN_W'(1))];

    assign pat_rd_en  = (state_reg == ST_FIX_RD) || issue_en;
    assign pat_rd_row = (state_reg == ST_FIX_RD) ? cur_slot_reg : SLOT_W'(cnt_reg);

    assign result_load = (state_reg == ST_RESULT) && (!out_valid_reg || m_axis_tready);

    assign pmv_cmd.rd_en   = issue_en;
    assign pmv_cmd.wr_en   = proc_en && proc_active;
    assign pmv_cmd.clr_row = clr_en || fix_done;
    assign pmv_cmd.clr_all = result_load;
    assign pmv_clr_row     = fix_done ? cur_slot_reg : SLOT_W'(in_slot);

    mpsd_pat_mem #(
        .NUM_SLOTS       (NUM_SLOTS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .SLOT_W          (SLOT_W),
        .LANE_W          (LANE_W)
    ) u_pat_mem (
        .clk     (clk),
        .wr_en   (pat_wr_en),
        .wr_row  (SLOT_W'(in_slot)),
        .wr_lane (LANE_W'(in_pos)),
        .wr_data (in_char),
        .rd_en   (pat_rd_en),
        .rd_row  (pat_rd_row),
        .rd_data (pat_row)
    );

    mpsd_pmv_mem #(
        .NUM_SLOTS       (NUM_SLOTS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .SLOT_W          (SLOT_W)
    ) u_pmv_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (pmv_cmd),
        .rd_row  (SLOT_W'(cnt_reg)),
        .wr_row  (proc_slot),
        .clr_row (pmv_clr_row),
        .wr_data (pmv_new),
        .rd_data (pmv_rd_data)
    );

    mpsd_lane_update #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_lane_update (
        .pat_row   (pat_row),
        .start4    (start4_reg[proc_slot]),
        .vec_in    (pmv_rd_data),
        .text_char (cur_char_reg),
        .vec_out   (pmv_new)
    );

    // Slot descriptors: cleared by a clear transaction, set when a slot is fixed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                len_reg[i]     <= '0;
                seg_len_reg[i] <= '0;
            end
            start4_reg <= '0;
        end
        else if (fix_done)
        begin
            len_reg[cur_slot_reg]     <= idx_reg;
            seg_len_reg[cur_slot_reg] <= fix_seg_len;
            start4_reg[cur_slot_reg]  <= qualify;
        end
        else if (clr_en)
        begin
            len_reg[SLOT_W'(in_slot)]     <= '0;
            seg_len_reg[SLOT_W'(in_slot)] <= '0;
            start4_reg[SLOT_W'(in_slot)]  <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_last_reg  <= 1'b0;
            pct_found_reg <= 1'b0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_last_reg  <= cur_last_next;
            pct_found_reg <= pct_found_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_slot_reg  <= cur_slot_next;
        cur_pos_reg   <= cur_pos_next;
        cur_char_reg  <= cur_char_next;
        idx_reg       <= idx_next;
        pct_idx_reg   <= pct_idx_next;
        out_found_reg <= out_found_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_slot_next  = cur_slot_reg;
        cur_pos_next   = cur_pos_reg;
        cur_char_next  = cur_char_reg;
        cur_last_next  = cur_last_reg;
        idx_next       = idx_reg;
        pct_found_next = pct_found_reg;
        pct_idx_next   = pct_idx_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg || proc_hit;
        halted_next    = halted_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_found_next = out_found_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cur_last_next = s_axis_tlast;
                    priority if (pat_wr_en && s_axis_tlast)
                    begin
                        cur_slot_next  = SLOT_W'(in_slot);
                        cur_pos_next   = in_pos;
                        idx_next       = '0;
                        pct_found_next = 1'b0;
                        state_next     = ST_FIX_RD;
                    end
                    else if (in_action == ACT_TEXT)
                    begin
                        if (!halted_reg && (in_char != '0))
                        begin
                            cur_char_next = in_char;
                            cnt_next      = '0;
                            state_next    = ST_TXT_RUN;
                        end
                        else
                        begin
                            // A zero unit terminates the text; later units are ignored.
                            halted_next = 1'b1;
                            if (s_axis_tlast)
                            begin
                                state_next = ST_RESULT;
                            end
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_FIX_RD:
            begin
                state_next = ST_FIX_SCAN;
            end

            ST_FIX_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    if ((idx_reg > LEN_W'(FMT_SKIP)) && (scan_char == PERCENT_CHAR)
                        && !pct_found_reg)
                    begin
                        pct_found_next = 1'b1;
                        pct_idx_next   = idx_reg;
                    end
                    idx_next = idx_reg + LEN_W'(1);
                end
            end

            ST_TXT_RUN:
            begin
                if (cnt_reg == CNT_W'(NUM_SLOTS))
                begin
                    state_next = cur_last_reg ? ST_RESULT : ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_RESULT:
            begin
                if (result_load)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = hit_reg;
                    hit_next       = 1'b0;
                    halted_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_found_reg};

endmodule

@@ rtl/core/mpsd_checker.sv @@
// Port-level assertions for the multi-pattern substring detector, with bind.
`timescale 1ns / 1ps

module mpsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);
    import mpsd_pkg::*;

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // A result never appears in the cycle right after an accepted transaction.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_acc))
        else $error("result appeared right after an input transaction");

    // Fixing a slot takes the block off the input right after the final unit is accepted.
    a_fix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (s_axis_tuser == ACT_PATTERN) && s_axis_tlast
         && (7'(s_axis_tdata[4:0]) < 7'(NUM_SLOTS_DEF))) |=> !s_axis_tready)
        else $error("input accepted while a slot was being fixed");

    // A clear leaves the input ready right after it is accepted.
    a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (s_axis_tuser == ACT_CLEAR)) |=> s_axis_tready)
        else $error("clear stalled the input");

    // Only the found bit may be set.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
        else $error("padding bits of the result set");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind multi_pattern_substring_detector mpsd_checker u_mpsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ dv/mpsd_match_checker.sv @@
// Checker that predicts and compares the results of the substring detector.
`timescale 1ns / 1ps

module mpsd_match_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    output int          errors,
    output int          pending
);
    import mpsd_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;
    localparam int PLEN  = MAX_PATTERN_LEN_DEF;

    logic [CHAR_BITS-1:0] store [SLOTS][PLEN];
    int                   pat_len [SLOTS];
    int                   seg_start [SLOTS];
    int                   seg_len [SLOTS];
    bit [PLEN-1:0]        partial [SLOTS];
    bit                   hit;
    bit                   halted;
    bit                   found_expected [$];

    initial
    begin
        errors = 0;
        hit    = 0;
        halted = 0;
        foreach (store[s, p]) store[s][p] = '0;
        foreach (pat_len[s])
        begin
            pat_len[s]   = 0;
            seg_start[s] = 0;
            seg_len[s]   = 0;
            partial[s]   = '0;
        end
    end

    assign pending = found_expected.size();

    // Fixes the length and search segment of a slot whose final unit arrived.
    task automatic fix_slot(input int s, input int pos);
        int len;
        int q;
        len = 0;
        while (len <= pos && store[s][len] != '0)
            len++;
        pat_len[s]   = len;
        seg_start[s] = 0;
        seg_len[s]   = len;
        if (len > FMT_SKIP && store[s][0] == PERCENT_CHAR)
        begin
            for (q = FMT_SKIP + 1; q < len; q++)
                if (store[s][q] == PERCENT_CHAR)
                    break;
            if (q < len)
            begin
                seg_start[s] = FMT_SKIP;
                seg_len[s]   = q - FMT_SKIP;
            end
        end
        partial[s] = '0;
    endtask

    // Shift-and update of every loaded slot for one text unit.
    task automatic scan_text_unit(input logic [CHAR_BITS-1:0] c);
        int n;
        for (int s = 0; s < SLOTS; s++)
        begin
            n = seg_len[s];
            if (pat_len[s] != 0 && n != 0)
            begin
                for (int k = n - 1; k > 0; k--)
                    partial[s][k] = partial[s][k-1] && store[s][seg_start[s] + k] == c;
                partial[s][0] = store[s][seg_start[s]] == c;
                if (partial[s][n-1])
                    hit = 1;
            end
        end
    endtask

    task automatic track_transaction(input logic [1:0] act, input int s, input int pos,
                                     input logic [CHAR_BITS-1:0] c, input bit lst);
        case (act)
            ACT_CLEAR:
                if (s < SLOTS)
                begin
                    pat_len[s]   = 0;
                    seg_start[s] = 0;
                    seg_len[s]   = 0;
                    partial[s]   = '0;
                end
            ACT_PATTERN:
                if (s < SLOTS && pos < PLEN)
                begin
                    store[s][pos] = c;
                    if (lst)
                        fix_slot(s, pos);
                end
            ACT_TEXT:
            begin
                if (!halted)
                begin
                    if (c == '0)
                        halted = 1;
                    else
                        scan_text_unit(c);
                end
                if (lst)
                begin
                    found_expected.push_back(hit);
                    hit    = 0;
                    halted = 0;
                    foreach (partial[i]) partial[i] = '0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                track_transaction(s_axis_tuser, int'(s_axis_tdata[4:0]),
                                  int'(s_axis_tdata[12:5]), s_axis_tdata[28:13],
                                  s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (found_expected.size() == 0)
                begin
                    $display("%0t: result with none expected, expected none, actual %h",
                             $realtime, m_axis_tdata);
                    errors++;
                end
                else if (m_axis_tdata !== {7'd0, found_expected[0]})
                begin
                    $display("%0t: found mismatch, expected %h, actual %h", $realtime,
                             {7'd0, found_expected[0]}, m_axis_tdata);
                    errors++;
                    void'(found_expected.pop_front());
                end
                else
                    void'(found_expected.pop_front());
            end
        end
    end

endmodule

@@ dv/tb.sv @@
// Testbench top: stimulus, receiver stalls and verdict for the substring detector.
`timescale 1ns / 1ps

module tb;
    import mpsd_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;
    localparam int PLEN  = MAX_PATTERN_LEN_DEF;

    // Action code that the block ignores.
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic [1:0]  s_axis_tuser = ACT_CLEAR;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;
    int          errors;
    int          pending;

    // Positions written so far per slot; a final unit is only sent once all
    // positions below it hold data, so fixing a slot never reads stale store.
    bit          written [SLOTS][PLEN];
    int          burst_left = 0;
    int          items_sent = 0;
    int          cyc = 0;
    int          hold_cnt = 0;
    bit          hold_arm = 0;
    bit          hold_done = 0;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    multi_pattern_substring_detector uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mpsd_match_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending)
    );

    // The receiver cycles through stall styles picked by a free-running counter.
    // Once the stimulus arms it, it holds off while a hold counter runs down, so
    // that the result register stays full and the block has to stall its input.
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (hold_cnt != 0)
        begin
            hold_cnt      <= hold_cnt - 1;
            m_axis_tready <= 0;
        end
        else if (hold_arm && !hold_done)
        begin
            hold_cnt      <= 400;
            hold_done     <= 1;
            m_axis_tready <= 0;
        end
        else
            case (cyc[7:6])
                2'd0: m_axis_tready <= 1;
                2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2: m_axis_tready <= (cyc[1:0] == 2'd0);
                default: m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
    end

    // Offers one transaction and waits for it to be taken. The sender runs in
    // bursts; between bursts it usually idles for a random number of cycles.
    task automatic send_unit(input logic [1:0] act, input int s, input int pos,
                             input logic [15:0] c, input bit lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'd0, c, pos[7:0], s[4:0]};
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (act == ACT_PATTERN && s < SLOTS)
            written[s][pos] = 1;
        burst_left--;
        items_sent++;
    endtask

    // Mostly a small alphabet so that segments actually occur in the text.
    function automatic logic [15:0] pick_unit();
        case ($urandom_range(0, 9))
            0:       return 16'h0025;
            1:       return 16'($urandom);
            default: return 16'h0061 + 16'($urandom_range(0, 2));
        endcase
    endfunction

    task automatic load_pattern(input int s, input logic [15:0] units[$]);
        for (int i = 0; i < units.size(); i++)
            send_unit(ACT_PATTERN, s, i, units[i], i == units.size() - 1);
    endtask

    task automatic send_text(input logic [15:0] units[$]);
        for (int i = 0; i < units.size(); i++)
            send_unit(ACT_TEXT, 0, 0, units[i], i == units.size() - 1);
    endtask

    task automatic random_pattern();
        logic [15:0] units[$];
        int          s;
        int          len;
        s   = $urandom_range(0, SLOTS - 1);
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        if ($urandom_range(0, 2) == 0)
        begin
            // Format-prefixed pattern, with or without a closing percent sign.
            units.push_back(16'h0025);
            repeat (3) units.push_back(pick_unit());
            repeat ($urandom_range(1, 3)) units.push_back(16'h0061 + 16'($urandom_range(0, 2)));
            if ($urandom_range(0, 2) != 0)
                units.push_back(16'h0025);
            repeat ($urandom_range(0, 2)) units.push_back(pick_unit());
        end
        else
            repeat (len) units.push_back(pick_unit());
        if ($urandom_range(0, 19) == 0)
            units[$urandom_range(0, units.size() - 1)] = 16'h0000;
        load_pattern(s, units);
    endtask

    task automatic random_text();
        logic [15:0] units[$];
        repeat ($urandom_range(1, 14))
            units.push_back(($urandom_range(0, 29) == 0) ? 16'h0000 : pick_unit());
        send_text(units);
    endtask

    // Noise: ignored actions, slots out of range, clears of random slots, stray
    // pattern units and final units at positions whose prefix is already written.
    task automatic random_noise();
        int s;
        int pos;
        bit ok;
        case ($urandom_range(0, 4))
            0: send_unit(ACT_UNKNOWN, $urandom_range(0, 31), $urandom_range(0, 255),
                         16'($urandom), 1'($urandom_range(0, 1)));
            1: send_unit(ACT_PATTERN, $urandom_range(SLOTS, 31), $urandom_range(0, 255),
                         16'($urandom), 1'($urandom_range(0, 1)));
            2: send_unit(ACT_CLEAR, $urandom_range(0, 31), $urandom_range(0, 255),
                         16'($urandom), 1'($urandom_range(0, 1)));
            3: send_unit(ACT_PATTERN, $urandom_range(0, SLOTS - 1), $urandom_range(0, 255),
                         16'($urandom), 0);
            default:
            begin
                s   = $urandom_range(0, SLOTS - 1);
                pos = $urandom_range(0, 12);
                ok  = 1;
                for (int i = 0; i < pos; i++)
                    if (!written[s][i])
                        ok = 0;
                if (ok)
                    send_unit(ACT_PATTERN, s, pos, pick_unit(), 1);
            end
        endcase
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: plain and format-prefixed patterns, an empty pattern, extreme
        // field values, a zero text unit, an unknown action and a clear.
        load_pattern(0, '{16'h0061, 16'h0062});
        load_pattern(1, '{16'h0025, 16'h0078, 16'h0079, 16'h007A, 16'h0051, 16'h0052,
                          16'h0025, 16'h0074});
        load_pattern(2, '{16'h0000});
        send_unit(ACT_PATTERN, 17, 255, 16'hFFFF, 0);
        send_unit(ACT_PATTERN, 31, 255, 16'hFFFF, 1);
        send_unit(ACT_UNKNOWN, 31, 255, 16'hFFFF, 1);
        send_text('{16'h0063, 16'h0061, 16'h0062});
        send_text('{16'h0000, 16'h0061, 16'h0062});
        send_text('{16'h0051, 16'h0052});
        send_text('{16'h0061, 16'h0000, 16'h0062});
        send_unit(ACT_CLEAR, 0, 0, 16'h0000, 0);
        send_text('{16'h0061, 16'h0062, 16'hFFFF});

        // Random part, with the long receiver hold-off early on.
        while (items_sent < 1900)
        begin
            if (items_sent > 200)
                hold_arm = 1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: random_text();
                5, 6, 7:       random_pattern();
                8:             send_unit(ACT_CLEAR, $urandom_range(0, SLOTS - 1), 0, 16'h0000, 0);
                default:       random_noise();
            endcase
        end
        s_axis_tvalid <= 0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
